// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the character write sequencer.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is high.
`define CLSQ_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("clsq assertion failed");

// Clocked check that also holds during reset.
`define CLSQ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("clsq assertion failed");

`endif

// ===== src/clsq_pkg.sv =====
// ---------------------------------------------------------------------------
// clsq_pkg
// Types and constants of the character LCD write sequencer.
// ---------------------------------------------------------------------------
package clsq_pkg;

  typedef enum logic [1:0] {
    MODE_CHAR   = 2'd0,
    MODE_STATUS = 2'd1,
    MODE_ALLOW  = 2'd2,
    MODE_BREAK  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    OP_DATA = 2'd0,
    OP_CTRL = 2'd1,
    OP_READ = 2'd2
  } bus_op_t;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_ADDR    = 3'd1,
    ST_SETADDR = 3'd2,
    ST_CMD     = 3'd3,
    ST_CHAR    = 3'd4
  } step_t;

  localparam int MAX_RES = 6;

  localparam logic [6:0] LINE_END    = 7'd15;
  localparam logic [6:0] SECOND_LINE = 7'h40;

  localparam logic [7:0] CTL_STATUS_BEGIN = 8'h03;
  localparam logic [7:0] CTL_STATUS_END   = 8'h02;
  localparam logic [7:0] CTL_CMD_STROBE   = 8'h01;
  localparam logic [7:0] CTL_CMD_RELEASE  = 8'h00;
  localparam logic [7:0] CTL_CHR_STROBE   = 8'h05;
  localparam logic [7:0] CTL_CHR_RELEASE  = 8'h04;
  localparam logic [7:0] SET_ADDR_BYTE    = 8'hC0;

  localparam logic [7:0] CHAR_BLOCK   = 8'h42;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  localparam logic [7:0] CLEAR_CMDS [4] = '{8'h01, 8'h06, 8'h0f, 8'h02};

  typedef struct packed {
    step_t      step;
    logic [7:0] pending_char;
    logic       line_break_pending;
    logic       output_blocked;
    logic [2:0] clear_command_index;
    logic       inside_clear;
  } seq_state_t;

  typedef struct packed {
    bus_op_t    op;
    logic [7:0] value;
    logic       last;
    logic       finished;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] item;
    logic [2:0]         n;
  } res_list_t;

endpackage

// ===== src/clsq_req_if.sv =====
// ---------------------------------------------------------------------------
// clsq_req_if
// Input channel: mode and value with valid/ready handshake.
// ---------------------------------------------------------------------------
interface clsq_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] value;

  modport source (output valid, mode, value, input ready);
  modport sink (input valid, mode, value, output ready);
endinterface

// ===== src/clsq_rsp_if.sv =====
// ---------------------------------------------------------------------------
// clsq_rsp_if
// Output channel: one bus operation per item with valid/ready handshake.
// ---------------------------------------------------------------------------
interface clsq_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] bus_op;
  logic [7:0] bus_value;
  logic       last;
  logic       finished;

  modport source (output valid, bus_op, bus_value, last, finished, input ready);
  modport sink (input valid, bus_op, bus_value, last, finished, output ready);
endinterface

// ===== src/char_lcd_write_sequencer_top.sv =====
// ---------------------------------------------------------------------------
// char_lcd_write_sequencer_top
// Turns characters and status bytes into character LCD bus operations.
// An accepted item is held in the stage registers, then loaded into the output
// buffer that offers its operations. Throughput: one item per cycle for items
//   without operations while the buffer is free; others wait for the single output port to drain it.
// Reset (rst, synchronous): sequencer idle, output allowed, no break pending.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module char_lcd_write_sequencer_top
  import clsq_pkg::*;
(
  input logic        clk,
  input logic        rst,
  clsq_req_if.sink   req,
  clsq_rsp_if.source rsp
);

  logic       stg_valid;
  logic [1:0] stg_mode;
  logic [7:0] stg_value;

  seq_state_t state;
  seq_state_t state_next;
  res_list_t  ops;
  res_list_t  buf_q;
  logic [2:0] cnt;
  logic [2:0] rd;

  logic rsp_fire;
  logic buf_free;
  logic load;

  clsq_core u_core (
    .state      (state),
    .mode       (stg_mode),
    .value      (stg_value),
    .state_next (state_next),
    .ops        (ops)
  );

  assign rsp_fire  = rsp.valid && rsp.ready;
  assign buf_free  = (cnt == 3'd0) || (rsp_fire && rd == cnt - 3'd1);
  assign load      = stg_valid && buf_free;
  assign req.ready = !stg_valid || buf_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      stg_valid <= 1'b1;
    end else if (load) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      stg_mode  <= req.mode;
      stg_value <= req.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{step: ST_IDLE, pending_char: 8'h00, line_break_pending: 1'b0,
                 output_blocked: 1'b0, clear_command_index: 3'd0, inside_clear: 1'b0};
      cnt   <= 3'd0;
      rd    <= 3'd0;
    end else if (load) begin
      state <= state_next;
      cnt   <= ops.n;
      rd    <= 3'd0;
    end else if (rsp_fire) begin
      if (rd == cnt - 3'd1) begin
        cnt <= 3'd0;
        rd  <= 3'd0;
      end else begin
        rd <= rd + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_q <= ops;
    end
  end

  assign rsp.valid     = (cnt != 3'd0);
  assign rsp.bus_op    = buf_q.item[rd].op;
  assign rsp.bus_value = buf_q.item[rd].value;
  assign rsp.last      = buf_q.item[rd].last;
  assign rsp.finished  = buf_q.item[rd].finished;

  `CLSQ_ASSERT(a_rd_in_range, clk, rst, (cnt != 3'd0) |-> (rd < cnt))
  `CLSQ_ASSERT(a_cnt_bound, clk, rst, cnt <= 3'(MAX_RES))
  `CLSQ_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !rsp.valid)
  `CLSQ_ASSERT(a_tail_is_last, clk, rst, (rsp.valid && rd == cnt - 3'd1) |-> rsp.last)
  `CLSQ_ASSERT(a_finished_idle, clk, rst,
    (rsp.valid && rsp.finished) |-> (rsp.last && state.step == ST_IDLE))
  `CLSQ_ASSERT(a_busy_holds_stage, clk, rst, (stg_valid && !buf_free) |-> !req.ready)

endmodule

// ===== src/clsq_core.sv =====
// ---------------------------------------------------------------------------
// clsq_core
// Next-state and bus operation list for one input item.
// ---------------------------------------------------------------------------
module clsq_core
  import clsq_pkg::*;
(
  input  seq_state_t  state,
  input  logic [1:0]  mode,
  input  logic [7:0]  value,
  output seq_state_t  state_next,
  output res_list_t   ops
);

  function automatic res_list_t push(res_list_t l, bus_op_t op, logic [7:0] v);
    res_list_t r;
    r = l;
    if (r.n < 3'(MAX_RES)) begin
      r.item[r.n].op       = op;
      r.item[r.n].value    = v;
      r.item[r.n].last     = 1'b0;
      r.item[r.n].finished = 1'b0;
      r.n = r.n + 3'd1;
    end
    return r;
  endfunction

  function automatic res_list_t poll(res_list_t l);
    res_list_t r;
    r = push(push(l, OP_CTRL, CTL_STATUS_BEGIN), OP_READ, 8'h00);
    r.item[r.n - 3'd1].last = 1'b1;
    return r;
  endfunction

  function automatic res_list_t finish(res_list_t l);
    res_list_t r;
    r = l;
    if (r.n != 3'd0) begin
      r.item[r.n - 3'd1].last     = 1'b1;
      r.item[r.n - 3'd1].finished = 1'b1;
    end
    return r;
  endfunction

  seq_state_t s;
  res_list_t  l;
  logic       busy;
  logic [6:0] addr;
  logic       run_setaddr;
  logic       run_clear;

  always_comb begin
    s           = state;
    l           = '0;
    busy        = value[7];
    addr        = value[6:0];
    run_setaddr = 1'b0;
    run_clear   = 1'b0;
    case (mode)
      MODE_CHAR: begin
        if (state.step == ST_IDLE && !state.output_blocked && value != 8'h00) begin
          if (value == CHAR_BLOCK) begin
            s.output_blocked = 1'b1;
          end else begin
            s.pending_char        = value;
            s.inside_clear        = 1'b0;
            s.clear_command_index = 3'd0;
            l = poll(l);
            s.step = ST_ADDR;
          end
        end
      end
      MODE_STATUS: begin
        if (state.step != ST_IDLE) begin
          l = push(l, OP_CTRL, CTL_STATUS_END);
          case (state.step)
            ST_ADDR: begin
              if (addr > LINE_END && addr < SECOND_LINE) begin
                l = poll(l);
                s.step = ST_SETADDR;
              end else begin
                run_setaddr = 1'b1;
              end
            end
            ST_SETADDR: begin
              if (busy) begin
                l = poll(l);
              end else begin
                l = push(l, OP_DATA, SET_ADDR_BYTE);
                l = push(l, OP_CTRL, CTL_CMD_STROBE);
                l = push(l, OP_CTRL, CTL_CMD_RELEASE);
                run_setaddr = 1'b1;
              end
            end
            ST_CMD: begin
              if (busy) begin
                l = poll(l);
              end else begin
                l = push(l, OP_DATA, CLEAR_CMDS[state.clear_command_index[1:0]]);
                l = push(l, OP_CTRL, CTL_CMD_STROBE);
                l = push(l, OP_CTRL, CTL_CMD_RELEASE);
                if (state.clear_command_index < 3'd2) begin
                  s.clear_command_index = state.clear_command_index + 3'd1;
                  l = poll(l);
                end else if (state.clear_command_index == 3'd2) begin
                  l = poll(l);
                  s.step = ST_ADDR;
                end else begin
                  s.inside_clear        = 1'b0;
                  s.clear_command_index = 3'd0;
                  run_clear = 1'b1;
                end
              end
            end
            default: begin
              if (busy) begin
                l = poll(l);
              end else begin
                l = push(l, OP_DATA, state.inside_clear ? CHAR_ZERO : state.pending_char);
                l = push(l, OP_CTRL, CTL_CHR_STROBE);
                l = push(l, OP_CTRL, CTL_CHR_RELEASE);
                if (state.inside_clear) begin
                  s.clear_command_index = 3'd3;
                  l = poll(l);
                  s.step = ST_CMD;
                end else begin
                  l = finish(l);
                  s.step = ST_IDLE;
                end
              end
            end
          endcase
          if (run_setaddr) begin
            if (!s.inside_clear && s.line_break_pending) begin
              s.line_break_pending  = 1'b0;
              s.inside_clear        = 1'b1;
              s.clear_command_index = 3'd0;
              l = poll(l);
              s.step = ST_CMD;
            end else begin
              run_clear = 1'b1;
            end
          end
          if (run_clear) begin
            if (!s.inside_clear && s.pending_char == CHAR_NEWLINE) begin
              s.line_break_pending = 1'b1;
              l = finish(l);
              s.step = ST_IDLE;
            end else begin
              l = poll(l);
              s.step = ST_CHAR;
            end
          end
        end
      end
      MODE_ALLOW: begin
        s.output_blocked = 1'b0;
      end
      default: begin
        s.line_break_pending = 1'b1;
      end
    endcase
    state_next = s;
    ops        = l;
  end

endmodule
